[rtl/core/pdcm_pkg.sv]
// Shared package for the PCM decode and channel mix block.
// Holds sizing constants, encoding and register codes, and the types
// passed between the front, the queue and the back. No dependencies.
`timescale 1ns / 1ps

package pdcm_pkg;

    // Frame store size and derived widths
    localparam int MAX_CHANNELS = 8;
    localparam int OUT_LIMIT    = 8;
    localparam int SLOT_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = 4;               // channel count register width
    localparam int CMP_W        = 8;               // room for slot / index arithmetic
    localparam int SUM_W        = 32 + SLOT_W;     // exact sum of up to MAX samples
    localparam int DIV_W        = SLOT_W + 1;      // divisor holds up to MAX_CHANNELS
    localparam int STEP_W       = $clog2(SUM_W + 1);

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Sample encodings
    localparam logic [2:0] ENC_INT16 = 3'd0;
    localparam logic [2:0] ENC_OFS8  = 3'd1;
    localparam logic [2:0] ENC_FLOAT = 3'd2;
    localparam logic [2:0] ENC_INT24 = 3'd3;
    localparam logic [2:0] ENC_INT32 = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 4;
    localparam logic [1:0] CFG_ENC    = 2'd0;
    localparam logic [1:0] CFG_SRC    = 2'd1;
    localparam logic [1:0] CFG_TGT    = 2'd2;

    typedef struct packed {
        logic [2:0]       enc;
        logic [CNT_W-1:0] src;
        logic [CNT_W-1:0] tgt;
    } t_cfg;

    typedef struct packed {
        logic [31:0]       sample;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_qent;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ACC,
        ST_ABS,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_bstate;

endpackage

[rtl/core/pdcm_front.sv]
// Front end: accepts raw samples, checks the configuration, decodes to
// Q1.31 and tags each sample with its frame slot. Depends on pdcm_pkg.
`timescale 1ns / 1ps

module pdcm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [31:0]          i_sample_word,
    input  pdcm_pkg::t_cfg       i_cfg,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_q_push,
    output pdcm_pkg::t_qent      o_q_data
);

    // IEEE single to Q1.31, truncating, saturating, NaN to zero
    function automatic logic [31:0] decode_float(input logic [31:0] w);
        logic [7:0]  e;
        logic [22:0] f;
        logic [23:0] mant;
        logic [7:0]  e_eff;
        logic [31:0] mag;
        logic [31:0] sat;
        logic [31:0] res;
        e     = w[30:23];
        f     = w[22:0];
        sat   = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mant  = (e != 8'd0) ? {1'b1, f} : {1'b0, f};
        e_eff = (e != 8'd0) ? e : 8'd1;
        if (e_eff >= 8'd119) begin
            mag = {8'd0, mant} << (e_eff - 8'd119);
        end else begin
            mag = {8'd0, mant} >> (8'd119 - e_eff);
        end
        if (e == 8'hFF && f != 23'd0) begin
            res = 32'd0;
        end else if (e == 8'hFF || e_eff >= 8'd127) begin
            res = sat;
        end else begin
            res = w[31] ? (32'd0 - mag) : mag;
        end
        return res;
    endfunction

    function automatic logic [31:0] decode_sample(input logic [31:0] w,
                                                  input logic [2:0]  enc);
        logic [31:0] res;
        unique case (enc)
            pdcm_pkg::ENC_INT16: res = {w[15:0], 16'd0};
            pdcm_pkg::ENC_OFS8:  res = {~w[7], w[6:0], 24'd0};
            pdcm_pkg::ENC_FLOAT: res = decode_float(w);
            pdcm_pkg::ENC_INT24: res = {w[23:0], 8'd0};
            default:             res = w;
        endcase
        return res;
    endfunction

    logic [pdcm_pkg::SLOT_W-1:0] r_slot;
    logic [pdcm_pkg::SLOT_W-1:0] n_slot;
    logic [pdcm_pkg::SLOT_W-1:0] cur_slot;
    logic                        cfg_ok;
    logic                        accept;
    logic                        last;

    // Configuration check: bad encodings or counts drop the transaction
    assign cfg_ok = (i_cfg.enc <= pdcm_pkg::ENC_INT32)
        && (i_cfg.src != '0)
        && ({4'd0, i_cfg.src} <= pdcm_pkg::CMP_W'(pdcm_pkg::MAX_CHANNELS))
        && (i_cfg.tgt != '0)
        && ({4'd0, i_cfg.tgt} <= pdcm_pkg::CMP_W'(pdcm_pkg::OUT_LIMIT))
        && ({4'd0, i_cfg.tgt} <= pdcm_pkg::CMP_W'(pdcm_pkg::MAX_CHANNELS));

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept && cfg_ok;

    // Slot tracking; a lowered source count closes the frame at once
    always_comb begin
        if (pdcm_pkg::CMP_W'(r_slot) >= pdcm_pkg::CMP_W'(pdcm_pkg::MAX_CHANNELS)) begin
            cur_slot = '0;
        end else begin
            cur_slot = r_slot;
        end
        last   = (pdcm_pkg::CMP_W'(cur_slot) + pdcm_pkg::CMP_W'(1))
                 >= pdcm_pkg::CMP_W'(i_cfg.src);
        n_slot = last ? '0 : cur_slot + pdcm_pkg::SLOT_W'(1);
    end

    assign o_q_data.sample = decode_sample(i_sample_word, i_cfg.enc);
    assign o_q_data.slot   = cur_slot;
    assign o_q_data.last   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (o_q_push) begin
            r_slot <= n_slot;
        end
    end

endmodule

[rtl/core/pdcm_queue.sv]
// Short queue of decoded, slot-tagged samples between front and back.
// Depends on pdcm_pkg.
`timescale 1ns / 1ps

module pdcm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pdcm_pkg::t_qent  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output pdcm_pkg::t_qent  o_data
);

    pdcm_pkg::t_qent                r_mem [pdcm_pkg::QDEPTH];
    logic [pdcm_pkg::QPTR_W-1:0]    r_wr;
    logic [pdcm_pkg::QPTR_W-1:0]    r_rd;
    logic [pdcm_pkg::QCNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == pdcm_pkg::QCNT_W'(pdcm_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + pdcm_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + pdcm_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + pdcm_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - pdcm_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/pdcm_back.sv]
// Back end: fills the frame store, then emits the target channels by copy
// or by averaging with a bit-serial divider. Depends on pdcm_pkg.
`timescale 1ns / 1ps

module pdcm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdcm_pkg::t_cfg        i_cfg,
    input  logic                  i_q_empty,
    input  pdcm_pkg::t_qent       i_q_data,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [31:0]    o_out_sample,
    output logic [2:0]            o_out_channel,
    output logic                  o_frame_last
);

    localparam int SW = pdcm_pkg::SLOT_W;
    localparam int CW = pdcm_pkg::CMP_W;
    localparam int MW = pdcm_pkg::SUM_W;
    localparam int DW = pdcm_pkg::DIV_W;
    localparam int PW = pdcm_pkg::STEP_W;

    pdcm_pkg::t_bstate               r_state, n_state;
    logic [pdcm_pkg::CNT_W-1:0]      r_chan, n_chan;
    logic [SW-1:0]                   r_src, n_src;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [MW-1:0]                   r_sum, n_sum;
    logic [DW-1:0]                   r_cnt, n_cnt;
    logic [MW-1:0]                   r_quo, n_quo;
    logic [DW-1:0]                   r_rem, n_rem;
    logic [PW-1:0]                   r_step, n_step;
    logic                            r_neg, n_neg;
    logic [31:0]                     r_res, n_res;
    logic                            r_ov, n_ov;
    logic [31:0]                     r_osample, n_osample;
    logic [2:0]                      r_ochan, n_ochan;
    logic                            r_olast, n_olast;

    logic [31:0]                     r_store [pdcm_pkg::MAX_CHANNELS];
    logic                            st_we;
    logic [SW-1:0]                   rd_addr;
    logic [31:0]                     rd_data;
    logic                            copy_mode;
    logic                            chan_last;
    logic [DW:0]                     trial;
    logic                            trial_ge;

    assign copy_mode = (i_cfg.src <= i_cfg.tgt);
    assign chan_last = (CW'(r_chan) + CW'(1)) == CW'(i_cfg.tgt);
    assign rd_addr   = copy_mode ? r_src : r_idx[SW-1:0];
    assign rd_data   = r_store[rd_addr];

    // One restoring division step
    assign trial    = {r_rem, r_quo[MW-1]};
    assign trial_ge = trial >= {1'b0, r_cnt};

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_chan    = r_chan;
        n_src     = r_src;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_step    = r_step;
        n_neg     = r_neg;
        n_res     = r_res;
        n_ov      = r_ov && !i_pop;
        n_osample = r_osample;
        n_ochan   = r_ochan;
        n_olast   = r_olast;
        o_q_pop   = 1'b0;
        st_we     = 1'b0;
        unique case (r_state)
            pdcm_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    st_we   = 1'b1;
                    if (i_q_data.last) begin
                        n_chan  = '0;
                        n_src   = '0;
                        n_state = pdcm_pkg::ST_SETUP;
                    end
                end
            end
            pdcm_pkg::ST_SETUP: begin
                if (copy_mode) begin
                    n_res   = rd_data;
                    n_state = pdcm_pkg::ST_OUT;
                end else begin
                    n_idx   = CW'(r_chan);
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_state = pdcm_pkg::ST_ACC;
                end
            end
            pdcm_pkg::ST_ACC: begin
                n_sum = r_sum + {{(MW-32){rd_data[31]}}, rd_data};
                n_cnt = r_cnt + DW'(1);
                n_idx = r_idx + CW'(i_cfg.tgt);
                if (n_idx >= CW'(i_cfg.src)) begin
                    n_state = pdcm_pkg::ST_ABS;
                end
            end
            pdcm_pkg::ST_ABS: begin
                n_neg   = r_sum[MW-1];
                n_quo   = r_sum[MW-1] ? (MW'(0) - r_sum) : r_sum;
                n_rem   = '0;
                n_step  = '0;
                n_state = pdcm_pkg::ST_DIV;
            end
            pdcm_pkg::ST_DIV: begin
                n_rem  = trial_ge ? DW'(trial - {1'b0, r_cnt}) : trial[DW-1:0];
                n_quo  = {r_quo[MW-2:0], trial_ge};
                n_step = r_step + PW'(1);
                if (r_step == PW'(MW - 1)) begin
                    n_state = pdcm_pkg::ST_FIN;
                end
            end
            pdcm_pkg::ST_FIN: begin
                n_res   = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];
                n_state = pdcm_pkg::ST_OUT;
            end
            pdcm_pkg::ST_OUT: begin
                if (!r_ov || i_pop) begin
                    n_ov      = 1'b1;
                    n_osample = r_res;
                    n_ochan   = r_chan[2:0];
                    n_olast   = chan_last;
                    n_chan    = r_chan + pdcm_pkg::CNT_W'(1);
                    if ((CW'(r_src) + CW'(1)) >= CW'(i_cfg.src)) begin
                        n_src = '0;
                    end else begin
                        n_src = r_src + SW'(1);
                    end
                    n_state = chan_last ? pdcm_pkg::ST_IDLE : pdcm_pkg::ST_SETUP;
                end
            end
            default: n_state = pdcm_pkg::ST_IDLE;
        endcase
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[i_q_data.slot] <= i_q_data.sample;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdcm_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_chan    <= n_chan;
        r_src     <= n_src;
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        r_cnt     <= n_cnt;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_neg     <= n_neg;
        r_res     <= n_res;
        r_osample <= n_osample;
        r_ochan   <= n_ochan;
        r_olast   <= n_olast;
    end

    assign o_empty       = !r_ov;
    assign o_out_sample  = r_osample;
    assign o_out_channel = r_ochan;
    assign o_frame_last  = r_olast;

endmodule

[rtl/core/pcm_decode_channel_mix.sv]
// Top level of the PCM decode and channel mix block: configuration
// registers, front end, sample queue and back end.
// Depends on pdcm_pkg, pdcm_front, pdcm_queue and pdcm_back.
//
//   channel    handshake                      payload
//   -------    ---------                      -------
//   input      push / full (accept: push&!full) i_sample_word[31:0]
//   result     empty / pop (accept: pop&!empty) o_out_sample, o_out_channel, o_frame_last
//   config     i_cfg_we (no wait)              i_cfg_idx[1:0], i_cfg_data[3:0]
//
// The front takes one sample per cycle into a four-entry queue while it is not full;
// the back drains one queued sample per cycle into the frame store while idle. At
// frame end the back steps per target channel through SETUP and OUT when copying, and
// SETUP, ACC per source, ABS, DIV once per bit of the SUM_W (35) bit sum, FIN and OUT when
// averaging. Reset is synchronous, active low. Either side may stall independently.
`timescale 1ns / 1ps

module pcm_decode_channel_mix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pdcm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdcm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [31:0]                          i_sample_word,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [31:0]                   o_out_sample,
    output logic [2:0]                           o_out_channel,
    output logic                                 o_frame_last
);

    pdcm_pkg::t_cfg  r_cfg;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    pdcm_pkg::t_qent q_wdata;
    pdcm_pkg::t_qent q_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enc <= pdcm_pkg::ENC_INT16;
            r_cfg.src <= pdcm_pkg::CNT_W'(1);
            r_cfg.tgt <= pdcm_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pdcm_pkg::CFG_ENC) begin
                r_cfg.enc <= i_cfg_data[2:0];
            end else if (i_cfg_idx == pdcm_pkg::CFG_SRC) begin
                r_cfg.src <= i_cfg_data;
            end else if (i_cfg_idx == pdcm_pkg::CFG_TGT) begin
                r_cfg.tgt <= i_cfg_data;
            end
        end
    end

    pdcm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_sample_word (i_sample_word),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    pdcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    pdcm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_sample  (o_out_sample),
        .o_out_channel (o_out_channel),
        .o_frame_last  (o_frame_last)
    );

endmodule
